[src/spds_pkg.sv]
// Shared types, widths and constants for the sensor poll deadline scheduler.
// No dependencies; every other file but the divider imports this package.
`timescale 1ns / 1ps

package spds_pkg;

  localparam int TIME_W      = 48;
  localparam int FRAME_W     = 32;
  localparam int PERIOD_US_W = 26;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int MASK_W      = 5;
  localparam int SKIP_W      = 8;
  localparam int SIDX_W      = 3;

  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [FRAME_W-1:0] frame_t;

  localparam logic [CFG_IDX_W-1:0]   CFG_PERIOD_MS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0]   CFG_PRESENT_MASK = 1'd1;

  localparam logic [9:0]             US_PER_MS        = 10'd1000;
  localparam logic [PERIOD_US_W-1:0] PERIOD_US_RESET  = 26'd1000000;
  localparam logic [MASK_W-1:0]      MASK_RESET       = 5'd31;

  localparam logic KIND_START = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_START_WR,
    ST_SLOT_DIV,
    ST_START_ND,
    ST_PICK,
    ST_BEST,
    ST_BEST_WR,
    ST_NEXT,
    ST_SK_A,
    ST_SK_B,
    ST_DIV_FPER,
    ST_DIV_Q,
    ST_EMIT
  } state_t;

  // Saturating time sum; both operands are already within the time range.
  function automatic time_t sat_add(input time_t a, input time_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

endpackage

[src/spds_if.sv]
// Handshake channels of the scheduler: trigger items in, poll results out.
// Depends on spds_pkg for field widths.
`timescale 1ns / 1ps

interface spds_in_if;
  import spds_pkg::*;
  logic         valid;
  logic         ready;
  logic         kind;
  time_t        now_us;
  frame_t       frame_number;

  modport source (output valid, kind, now_us, frame_number, input ready);
  modport sink   (input valid, kind, now_us, frame_number, output ready);
endinterface

interface spds_out_if;
  import spds_pkg::*;
  logic              valid;
  logic              ready;
  logic              read_valid;
  logic [SIDX_W-1:0] sensor_index;
  logic [SKIP_W-1:0] skip_frames;
  logic              last;

  modport source (output valid, read_valid, sensor_index, skip_frames, last, input ready);
  modport sink   (input valid, read_valid, sensor_index, skip_frames, last, output ready);
endinterface

[src/sensor_poll_deadline_scheduler_core.sv]
// Sensor poll deadline scheduler, top level. One item at a time.
// Start item: one pass in the shared divider, none with no sensor present.
// Tick item: up to three one-entry-per-cycle due-time scans and up to two divider passes;
// a tick that is not due skips the scans.
// Result beats leave one per cycle, overlapping the next item, which waits while they are held.
// Synchronous active-low reset: due times and times zero, period 1000 ms, mask 31.
`timescale 1ns / 1ps

module sensor_poll_deadline_scheduler_core
  import spds_pkg::*;
#(
  parameter int NUM_SENSORS = 5,
  parameter int MAX_SKIP    = 255
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  spds_in_if.sink               in_ch,
  spds_out_if.source            out_ch
);

  localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int CNT_W = $clog2(NUM_SENSORS + 1);

  state_t state_r, state_nxt;

  // configuration
  logic [PERIOD_US_W-1:0] period_us_r;
  logic [MASK_W-1:0]      present_r;

  // scheduler state
  time_t  due_r [NUM_SENSORS];
  time_t  next_due_r, slot_r, start_time_r;
  frame_t start_frame_r;

  // per-item working registers
  logic                   kind_r;
  time_t                  now_r, sum_per_r, cand_r, best_due_r;
  time_t                  elapsed_r, remain_r;
  frame_t                 frame_r, fdiff_r;
  logic                   el_neg_r, best_ok_r;
  logic [IDX_W-1:0]       idx_r, best_idx_r;
  logic [NUM_SENSORS-1:0] pick_r;
  logic [SKIP_W-1:0]      skip_r;

  // combinational
  logic [NUM_SENSORS-1:0] pres_v;
  logic [CNT_W-1:0]       count;
  logic                   in_fire, last_idx, cmp_lt, hit;
  time_t                  due_sel, cmp_ref, sum_per, sum_slot;
  logic [TIME_W:0]        el_diff, rm_diff;
  frame_t                 fdiff;
  logic                   short_skip;
  logic [SKIP_W-1:0]      q_skip;

  // shared divider and result stage
  logic  div_start, div_busy, div_done;
  time_t div_a, div_b, div_quo;
  logic  emit_load, emit_idle;

  genvar gi;
  generate
    for (gi = 0; gi < NUM_SENSORS; gi++) begin : g_pres
      if (gi < MASK_W) begin : g_bit
        assign pres_v[gi] = present_r[gi];
      end else begin : g_none
        assign pres_v[gi] = 1'b0;
      end
    end
  endgenerate

  always_comb begin
    count = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      count = count + CNT_W'(pres_v[i]);
    end
  end

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign due_sel  = due_r[idx_r];
  assign last_idx = (idx_r == IDX_W'(NUM_SENSORS - 1));
  assign sum_per  = sat_add(now_r, TIME_W'(period_us_r));
  assign sum_slot = sat_add(now_r, slot_r);
  assign fdiff    = frame_r - start_frame_r;
  assign el_diff  = {1'b0, now_r} - {1'b0, start_time_r};
  assign rm_diff  = {1'b0, next_due_r} - {1'b0, now_r};

  // one comparator serves all three scans
  always_comb begin
    case (state_r)
      ST_PICK: cmp_ref = next_due_r;
      ST_BEST: cmp_ref = best_due_r;
      ST_NEXT: cmp_ref = cand_r;
      default: cmp_ref = next_due_r;
    endcase
    cmp_lt = (due_sel < cmp_ref);
    if (state_r == ST_BEST) begin
      hit = pres_v[idx_r] && (!best_ok_r || cmp_lt);
    end else begin
      hit = pres_v[idx_r] && cmp_lt;
    end
  end

  assign short_skip = (fdiff_r == '0) || el_neg_r || rm_diff[TIME_W] ||
                      (rm_diff[TIME_W-1:0] == '0);

  always_comb begin
    if (div_quo > TIME_W'(MAX_SKIP)) begin
      q_skip = SKIP_W'(MAX_SKIP);
    end else if (div_quo == '0) begin
      q_skip = SKIP_W'(1);
    end else begin
      q_skip = div_quo[SKIP_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        if (kind_r == KIND_START) state_nxt = ST_START_WR;
        else if (count == '0)     state_nxt = ST_EMIT;
        else if (now_r >= next_due_r) state_nxt = ST_PICK;
        else                      state_nxt = ST_SK_A;
      end
      ST_START_WR: begin
        state_nxt = (count == '0) ? ST_START_ND : ST_SLOT_DIV;
      end
      ST_SLOT_DIV: begin
        if (div_done) state_nxt = ST_START_ND;
      end
      ST_START_ND: state_nxt = ST_EMIT;
      ST_PICK: begin
        if (last_idx) state_nxt = ((|pick_r) || hit) ? ST_NEXT : ST_BEST;
      end
      ST_BEST: begin
        if (last_idx) state_nxt = ST_BEST_WR;
      end
      ST_BEST_WR: state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (last_idx) state_nxt = ST_SK_A;
      end
      ST_SK_A: state_nxt = ST_SK_B;
      ST_SK_B: begin
        state_nxt = short_skip ? ST_EMIT : ST_DIV_FPER;
      end
      ST_DIV_FPER: begin
        if (div_done) state_nxt = (div_quo == '0) ? ST_EMIT : ST_DIV_Q;
      end
      ST_DIV_Q: begin
        if (div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_idle) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    div_a       = remain_r;
    div_b       = div_quo;
    emit_load   = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_START_WR: begin
        div_start = (count != '0);
        div_a     = TIME_W'(period_us_r);
        div_b     = TIME_W'(count);
      end
      ST_SK_B: begin
        div_start = !short_skip;
        div_a     = elapsed_r;
        div_b     = TIME_W'(fdiff_r);
      end
      ST_DIV_FPER: begin
        div_start = div_done && (div_quo != '0);
        div_a     = remain_r;
        div_b     = div_quo;
      end
      ST_EMIT: emit_load = emit_idle;
      default: ;
    endcase
  end

  // control and scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      period_us_r   <= PERIOD_US_RESET;
      present_r     <= MASK_RESET;
      next_due_r    <= '0;
      slot_r        <= '0;
      start_time_r  <= '0;
      start_frame_r <= '0;
      for (int i = 0; i < NUM_SENSORS; i++) due_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PERIOD_MS:    period_us_r <= PERIOD_US_W'(cfg_wdata) * PERIOD_US_W'(US_PER_MS);
          CFG_PRESENT_MASK: present_r   <= cfg_wdata[MASK_W-1:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_PREP: begin
          if (kind_r == KIND_START) begin
            start_time_r  <= now_r;
            start_frame_r <= frame_r;
          end
        end
        ST_START_WR: begin
          for (int i = 0; i < NUM_SENSORS; i++) begin
            if (pres_v[i]) due_r[i] <= sum_per_r;
          end
          if (count == '0) slot_r <= '0;
        end
        ST_SLOT_DIV: begin
          if (div_done) slot_r <= div_quo;
        end
        ST_START_ND: next_due_r <= sum_slot;
        ST_PICK: begin
          if (hit) due_r[idx_r] <= sum_per_r;
        end
        ST_BEST_WR: due_r[best_idx_r] <= sum_per_r;
        ST_NEXT: begin
          if (last_idx) next_due_r <= hit ? due_sel : cand_r;
        end
        default: ;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          kind_r  <= in_ch.kind;
          now_r   <= in_ch.now_us;
          frame_r <= in_ch.frame_number;
        end
      end
      ST_PREP: begin
        sum_per_r <= sum_per;
        cand_r    <= sum_slot;
        idx_r     <= '0;
        pick_r    <= '0;
        best_ok_r <= 1'b0;
        skip_r    <= '0;
      end
      ST_START_ND: begin
        pick_r <= pres_v;
        skip_r <= (count != '0) ? SKIP_W'(1) : '0;
      end
      ST_PICK: begin
        if (hit) pick_r[idx_r] <= 1'b1;
        idx_r <= last_idx ? '0 : idx_r + 1'b1;
      end
      ST_BEST: begin
        if (hit) begin
          best_idx_r <= idx_r;
          best_due_r <= due_sel;
          best_ok_r  <= 1'b1;
        end
        idx_r <= last_idx ? '0 : idx_r + 1'b1;
      end
      ST_BEST_WR: pick_r[best_idx_r] <= 1'b1;
      ST_NEXT: begin
        if (hit) cand_r <= due_sel;
        idx_r <= last_idx ? '0 : idx_r + 1'b1;
      end
      ST_SK_A: begin
        fdiff_r   <= fdiff;
        elapsed_r <= el_diff[TIME_W-1:0];
        el_neg_r  <= el_diff[TIME_W];
      end
      ST_SK_B: begin
        remain_r <= rm_diff[TIME_W-1:0];
        if (short_skip) skip_r <= SKIP_W'(1);
      end
      ST_DIV_FPER: begin
        // zero frame period: saturate
        if (div_done && div_quo == '0) skip_r <= SKIP_W'(MAX_SKIP);
      end
      ST_DIV_Q: begin
        if (div_done) skip_r <= q_skip;
      end
      default: ;
    endcase
  end

  spds_divider #(
    .WIDTH (TIME_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_quo),
    .busy     (div_busy),
    .done     (div_done)
  );

  spds_emitter #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (emit_load && !div_busy),
    .mask   (pick_r),
    .skip   (skip_r),
    .idle   (emit_idle),
    .out_ch (out_ch)
  );

endmodule

[src/spds_divider.sv]
// Restoring divider, one quotient bit per cycle, shared by every division.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module spds_divider #(
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic [WIDTH-1:0] quotient,
  output logic             busy,
  output logic             done
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] div_r;
  logic [WIDTH:0]   rem_sh, diff;

  always_comb begin
    rem_sh = {rem_r, quo_r[WIDTH-1]};
    diff   = rem_sh - {1'b0, div_r};
    if (!diff[WIDTH]) begin
      rem_nxt = diff[WIDTH-1:0];
      quo_nxt = {quo_r[WIDTH-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[WIDTH-1:0];
      quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      cnt_r <= CNT_W'(WIDTH - 1);
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quotient = quo_r;
  assign busy     = busy_r;
  assign done     = done_r;

endmodule

[src/spds_emitter.sv]
// Result stage: holds the pick mask of one item and sends one beat per pick, or one beat with read_valid low if none.
// Depends on spds_pkg and the spds_out_if channel.
`timescale 1ns / 1ps

module spds_emitter
  import spds_pkg::*;
#(
  parameter int NUM_SENSORS = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic [NUM_SENSORS-1:0] mask,
  input  logic [SKIP_W-1:0]      skip,
  output logic                   idle,
  spds_out_if.source             out_ch
);

  localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  logic                   busy_r;
  logic [NUM_SENSORS-1:0] mask_r;
  logic [SKIP_W-1:0]      skip_r;
  logic [IDX_W-1:0]       lo_idx;
  logic [NUM_SENSORS-1:0] rest;
  logic                   is_last;

  always_comb begin
    lo_idx = '0;
    for (int i = NUM_SENSORS - 1; i >= 0; i--) begin
      if (mask_r[i]) lo_idx = IDX_W'(i);
    end
    // drop the lowest pick
    rest    = mask_r & (mask_r - 1'b1);
    is_last = (rest == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load && !busy_r) begin
      busy_r <= 1'b1;
    end else if (busy_r && out_ch.ready && is_last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !busy_r) begin
      mask_r <= mask;
      skip_r <= skip;
    end else if (busy_r && out_ch.ready) begin
      mask_r <= rest;
    end
  end

  assign idle                = !busy_r;
  assign out_ch.valid        = busy_r;
  assign out_ch.read_valid   = |mask_r;
  assign out_ch.sensor_index = (|mask_r) ? SIDX_W'(lo_idx) : '0;
  assign out_ch.skip_frames  = is_last ? skip_r : '0;
  assign out_ch.last         = is_last;

endmodule
